@@ src/tsl_pkg.sv @@
`default_nettype none

package tsl_pkg;

	localparam int CHANNELS      = 16;
	localparam int LANES         = 8;
	localparam int SAMPLE_FIELDS = 8;

	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = (CHANNELS > SAMPLE_W) ? SAMPLE_W : CHANNELS;
	localparam int LANE_N   = (LANES < SAMPLE_FIELDS) ? LANES : SAMPLE_FIELDS;
	localparam int VCNT_W   = 4;
	localparam int OFF_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 16;

	localparam logic [OFF_W-1:0] OFFSET_MASK = 3'h7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_MASK  = 3'd0,
		REG_LEVEL_VALUE = 3'd1,
		REG_RISE_MASK   = 3'd2,
		REG_FALL_MASK   = 3'd3
	} reg_idx_t;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		chan_t level_mask;
		chan_t level_value;
		chan_t rise_mask;
		chan_t fall_mask;
	} trig_cfg_t;

endpackage

`default_nettype wire

@@ src/tsl_group_if.sv @@
`default_nettype none

interface tsl_group_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_0;
	logic [15:0] sample_1;
	logic [15:0] sample_2;
	logic [15:0] sample_3;
	logic [15:0] sample_4;
	logic [15:0] sample_5;
	logic [15:0] sample_6;
	logic [15:0] sample_7;
	logic [3:0]  valid_count;
	logic        armed;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
			sample_6, sample_7, valid_count, armed,
		input  ready
	);
	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
			sample_6, sample_7, valid_count, armed,
		output ready
	);
endinterface

`default_nettype wire

@@ src/tsl_result_if.sv @@
`default_nettype none

interface tsl_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] hit_offset;
	logic       found;

	modport source (
		output valid, hit_offset, found,
		input  ready
	);
	modport sink (
		input  valid, hit_offset, found,
		output ready
	);
endinterface

`default_nettype wire

@@ src/tsl_lane.sv @@
`default_nettype none

module tsl_lane (
	input  var tsl_pkg::trig_cfg_t cfg,
	input  var tsl_pkg::chan_t     prev,
	input  var tsl_pkg::chan_t     cur,
	output logic                   hit
);
	import tsl_pkg::*;

	logic level_ok;
	logic rise_ok;
	logic fall_ok;

	assign level_ok = (cur & cfg.level_mask) == cfg.level_value;
	assign rise_ok  = ((prev & cfg.rise_mask) == '0) && ((cur & cfg.rise_mask) == cfg.rise_mask);
	assign fall_ok  = ((prev & cfg.fall_mask) == cfg.fall_mask) && ((cur & cfg.fall_mask) == '0);
	assign hit      = level_ok && rise_ok && fall_ok;

endmodule

`default_nettype wire

@@ src/tsl_merge.sv @@
`default_nettype none

module tsl_merge (
	input  wire logic [tsl_pkg::LANE_N-1:0] hits,
	input  wire logic                       armed,
	output logic [tsl_pkg::OFF_W-1:0]       offset,
	output logic                            found
);
	import tsl_pkg::*;

	always_comb begin
		offset = '0;
		found  = 1'b0;
		if (armed) begin
			for (int k = LANE_N - 1; k >= 0; k--) begin
				if (hits[k]) begin
					offset = OFF_W'(k) & OFFSET_MASK;
					found  = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/trigger_sample_locator_core.sv @@
// Channel   Role    Payload
// samples   sink    sample_0..sample_7, valid_count, armed
// trigger   source  hit_offset, found
// cfg       write   cfg_we, cfg_index, cfg_wdata (level_mask, level_value, rise_mask, fall_mask)
//
// One group per cycle while samples.ready is high; a group lands in hits_s1, then the output register.
// Lane compares and the stored last sample settle in the accept cycle; the
// merge stage picks the lowest hit into the output register.
// arst_n clears the config, the stored sample and both stage valids; data registers are not reset.
// A stalled result holds; groups keep flowing while the stage behind it is free.
`default_nettype none

module trigger_sample_locator_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tsl_group_if.sink                           samples,
	tsl_result_if.source                        trigger,
	input  wire logic                           cfg_we,
	input  wire logic [tsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tsl_pkg::CFG_W-1:0]      cfg_wdata
);
	import tsl_pkg::*;

	trig_cfg_t cfg_q;
	chan_t     prev_q;
	chan_t     cur [SAMPLE_FIELDS];
	chan_t     lane_prev [LANE_N];
	logic [LANE_N-1:0] hits;
	logic [LANE_N-1:0] hits_s1;
	logic              armed_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic [OFF_W-1:0]  offset_q;
	logic              found_q;
	logic [OFF_W-1:0]  merge_offset;
	logic              merge_found;
	logic              take;
	logic              advance;
	logic              out_free;
	logic [VCNT_W-1:0] vsat;
	logic [OFF_W-1:0]  last_sel;

	assign cur[0] = samples.sample_0[CHAN_W-1:0];
	assign cur[1] = samples.sample_1[CHAN_W-1:0];
	assign cur[2] = samples.sample_2[CHAN_W-1:0];
	assign cur[3] = samples.sample_3[CHAN_W-1:0];
	assign cur[4] = samples.sample_4[CHAN_W-1:0];
	assign cur[5] = samples.sample_5[CHAN_W-1:0];
	assign cur[6] = samples.sample_6[CHAN_W-1:0];
	assign cur[7] = samples.sample_7[CHAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL_MASK:  cfg_q.level_mask  <= cfg_wdata[CHAN_W-1:0];
				REG_LEVEL_VALUE: cfg_q.level_value <= cfg_wdata[CHAN_W-1:0];
				REG_RISE_MASK:   cfg_q.rise_mask   <= cfg_wdata[CHAN_W-1:0];
				REG_FALL_MASK:   cfg_q.fall_mask   <= cfg_wdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	genvar k;
	generate
		for (k = 0; k < LANE_N; k++) begin : g_lane
			if (k == 0) begin : g_first
				assign lane_prev[k] = prev_q;
			end else begin : g_next
				assign lane_prev[k] = cur[k-1];
			end
			tsl_lane u_lane (
				.cfg  (cfg_q),
				.prev (lane_prev[k]),
				.cur  (cur[k]),
				.hit  (hits[k])
			);
		end
	endgenerate

	assign out_free      = !out_valid_q || trigger.ready;
	assign advance       = valid_s1 && out_free;
	assign samples.ready = !valid_s1 || out_free;
	assign take          = samples.valid && samples.ready;

	always_comb begin
		vsat = samples.valid_count;
		if (vsat > VCNT_W'(LANE_N))
			vsat = VCNT_W'(LANE_N);
		last_sel = OFF_W'(vsat - VCNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (take && (vsat != '0)) begin
			prev_q <= cur[last_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hits_s1  <= hits;
			armed_s1 <= samples.armed;
		end
	end

	tsl_merge u_merge (
		.hits   (hits_s1),
		.armed  (armed_s1),
		.offset (merge_offset),
		.found  (merge_found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			offset_q <= merge_offset;
			found_q  <= merge_found;
		end
	end

	assign trigger.valid      = out_valid_q;
	assign trigger.hit_offset = offset_q;
	assign trigger.found      = found_q;

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0)
		else $error("offset nonzero without a hit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> valid_s1 && out_valid_q && !trigger.ready)
		else $error("input stalled while pipeline can move");

	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced beat did not reach output");

	a_disarmed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !armed_s1 |=> !found_q)
		else $error("hit reported for a disarmed group");

endmodule

`default_nettype wire

@@ tb/sv/trigger_sample_locator_core_test.sv @@
`timescale 1ns / 100ps

module trigger_sample_locator_core_test;
	import tsl_pkg::*;

	localparam int CYCLE_LIMIT       = 200000;
	localparam int RANDOM_PHASES     = 8;
	localparam int PHASE_GROUPS      = 104;
	localparam int SPARE_INDEX_FIRST = 4;
	localparam int SPARE_INDEX_LAST  = (1 << CFG_IDX_W) - 1;
	localparam int REPORT_LIMIT      = 10;

	typedef struct packed {
		logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] lane;
		logic [VCNT_W-1:0]                      vcount;
		logic                                   armed;
	} sample_group_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             found;
	} trig_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	tsl_group_if  samples_bus ();
	tsl_result_if trigger_bus ();

	trigger_sample_locator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_bus),
		.trigger   (trigger_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	trig_cfg_t    trig_cfg = '0;
	chan_t        held_sample = '0;
	trig_result_t expected_triggers[$];

	bit src_gaps    = 1'b1;
	bit sink_stalls = 1'b1;
	int cycle_count = 0;
	int mismatches  = 0;
	int groups_sent = 0;
	int triggers_seen = 0;
	int settings_used = 0;

	always #4 clk = ~clk;

	function automatic trig_result_t locate_trigger(input sample_group_t g);
		trig_result_t r;
		chan_t        prior;
		chan_t        cur;
		int           vc;
		int           i;
		r = '0;
		prior = held_sample;
		if (g.armed) begin
			for (i = 0; i < LANE_N; i++) begin
				cur = g.lane[i][CHAN_W-1:0];
				if (!r.found &&
					(cur & trig_cfg.level_mask) == trig_cfg.level_value &&
					(prior & trig_cfg.rise_mask) == '0 &&
					(cur & trig_cfg.rise_mask) == trig_cfg.rise_mask &&
					(prior & trig_cfg.fall_mask) == trig_cfg.fall_mask &&
					(cur & trig_cfg.fall_mask) == '0) begin
					r.offset = OFF_W'(i) & OFFSET_MASK;
					r.found = 1'b1;
				end
				prior = cur;
			end
		end
		vc = int'(g.vcount);
		if (vc > LANE_N)
			vc = LANE_N;
		if (vc > 0)
			held_sample = g.lane[vc-1][CHAN_W-1:0];
		return r;
	endfunction

	function automatic sample_group_t uniform_group(input logic [SAMPLE_W-1:0] value,
		input logic [VCNT_W-1:0] vcount, input logic armed);
		sample_group_t g;
		int            i;
		for (i = 0; i < SAMPLE_FIELDS; i++)
			g.lane[i] = value;
		g.vcount = vcount;
		g.armed = armed;
		return g;
	endfunction

	function automatic logic [SAMPLE_W-1:0] sparse_bits();
		return SAMPLE_W'($urandom) & SAMPLE_W'($urandom) & SAMPLE_W'($urandom);
	endfunction

	function automatic trig_cfg_t make_trigger();
		trig_cfg_t c;
		c.level_mask = SAMPLE_W'($urandom) & SAMPLE_W'($urandom);
		c.level_value = SAMPLE_W'($urandom) & c.level_mask;
		if ($urandom_range(0, 7) == 0)
			c.level_value = c.level_value | (~c.level_mask & sparse_bits());
		c.rise_mask = ($urandom_range(0, 5) == 0) ? '0 : sparse_bits();
		c.fall_mask = sparse_bits();
		if ($urandom_range(0, 7) != 0)
			c.fall_mask = c.fall_mask & ~c.rise_mask;
		return c;
	endfunction

	function automatic sample_group_t make_group();
		sample_group_t g;
		chan_t         hit;
		int            style;
		int            k;
		int            i;
		int            pick;
		style = $urandom_range(0, 9);
		for (i = 0; i < SAMPLE_FIELDS; i++)
			g.lane[i] = SAMPLE_W'($urandom);
		if (style < 3) begin
			for (i = 1; i < SAMPLE_FIELDS; i++)
				g.lane[i] = g.lane[i-1] ^ sparse_bits();
		end
		if (style < 8) begin
			k = $urandom_range(0, SAMPLE_FIELDS - 1);
			hit = (g.lane[k] & ~trig_cfg.level_mask) |
				(trig_cfg.level_value & trig_cfg.level_mask);
			hit = (hit | trig_cfg.rise_mask) & ~trig_cfg.fall_mask;
			g.lane[k] = hit;
			if (k > 0)
				g.lane[k-1] = (g.lane[k-1] & ~trig_cfg.rise_mask) | trig_cfg.fall_mask;
		end
		pick = $urandom_range(0, 9);
		if (pick < 6)
			g.vcount = VCNT_W'(SAMPLE_FIELDS);
		else if (pick < 8)
			g.vcount = VCNT_W'($urandom_range(1, SAMPLE_FIELDS - 1));
		else if (pick == 8)
			g.vcount = '0;
		else
			g.vcount = VCNT_W'($urandom_range(SAMPLE_FIELDS + 1, (1 << VCNT_W) - 1));
		g.armed = ($urandom_range(0, 4) != 0);
		return g;
	endfunction

	task automatic send_group(input sample_group_t g);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			samples_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		samples_bus.valid       <= 1'b1;
		samples_bus.sample_0    <= g.lane[0];
		samples_bus.sample_1    <= g.lane[1];
		samples_bus.sample_2    <= g.lane[2];
		samples_bus.sample_3    <= g.lane[3];
		samples_bus.sample_4    <= g.lane[4];
		samples_bus.sample_5    <= g.lane[5];
		samples_bus.sample_6    <= g.lane[6];
		samples_bus.sample_7    <= g.lane[7];
		samples_bus.valid_count <= g.vcount;
		samples_bus.armed       <= g.armed;
		@(posedge clk);
		while (samples_bus.ready !== 1'b1)
			@(posedge clk);
		expected_triggers.push_back(locate_trigger(g));
		groups_sent++;
	endtask

	task automatic wait_idle();
		samples_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_triggers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_LEVEL_MASK:  trig_cfg.level_mask  = data[CHAN_W-1:0];
			REG_LEVEL_VALUE: trig_cfg.level_value = data[CHAN_W-1:0];
			REG_RISE_MASK:   trig_cfg.rise_mask   = data[CHAN_W-1:0];
			REG_FALL_MASK:   trig_cfg.fall_mask   = data[CHAN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_trigger(input trig_cfg_t c);
		cfg_write(REG_LEVEL_MASK, c.level_mask);
		cfg_write(REG_LEVEL_VALUE, c.level_value);
		cfg_write(REG_RISE_MASK, c.rise_mask);
		cfg_write(REG_FALL_MASK, c.fall_mask);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic test_reset_state();
		send_group(uniform_group(16'h0000, 4'd8, 1'b1));
		send_group(uniform_group(16'hFFFF, 4'd8, 1'b0));
	endtask

	task automatic test_level_trigger();
		sample_group_t g;
		trig_cfg_t     c;
		wait_idle();
		c = '0;
		c.level_mask = 16'hFFFF;
		c.level_value = 16'hA5C3;
		program_trigger(c);
		g = uniform_group(16'h0000, 4'd8, 1'b1);
		g.lane[5] = 16'hA5C3;
		send_group(g);
		g.lane[5] = 16'h0000;
		g.lane[7] = 16'hA5C3;
		g.vcount = 4'd4;
		send_group(g);
		send_group(uniform_group(16'h5A3C, 4'd8, 1'b1));
		send_group(uniform_group(16'hA5C3, 4'd8, 1'b0));
		wait_idle();
		c.level_mask = 16'h00FF;
		c.level_value = 16'h01C3;
		program_trigger(c);
		send_group(uniform_group(16'h01C3, 4'd8, 1'b1));
		send_group(uniform_group(16'hFFFF, 4'd8, 1'b1));
	endtask

	task automatic test_edge_trigger();
		sample_group_t g;
		trig_cfg_t     c;
		int            i;
		wait_idle();
		c = '0;
		c.rise_mask = 16'h0001;
		c.fall_mask = 16'h8000;
		program_trigger(c);
		g = uniform_group(16'h0001, 4'd1, 1'b1);
		g.lane[0] = 16'h8000;
		send_group(g);
		send_group(uniform_group(16'h0001, 4'd0, 1'b1));
		g = uniform_group(16'h0001, 4'd15, 1'b1);
		g.lane[7] = 16'h8000;
		send_group(g);
		send_group(uniform_group(16'hFFFF, 4'd8, 1'b1));
		g = uniform_group(16'h8000, 4'd8, 1'b1);
		for (i = 1; i < SAMPLE_FIELDS; i += 2)
			g.lane[i] = 16'h0001;
		send_group(g);
		wait_idle();
		c = '0;
		c.rise_mask = '1;
		program_trigger(c);
		g = uniform_group(16'h0000, 4'd8, 1'b1);
		for (i = 1; i < SAMPLE_FIELDS; i += 2)
			g.lane[i] = 16'hFFFF;
		send_group(g);
		wait_idle();
		c = '0;
		c.fall_mask = '1;
		program_trigger(c);
		g = uniform_group(16'hFFFF, 4'd8, 1'b1);
		for (i = 1; i < SAMPLE_FIELDS; i += 2)
			g.lane[i] = 16'h0000;
		send_group(g);
		wait_idle();
		c = '0;
		c.level_mask = '1;
		c.level_value = '1;
		program_trigger(c);
		g = uniform_group(16'hFFFF, 4'd8, 1'b1);
		g.lane[0] = 16'hFFFE;
		send_group(g);
	endtask

	task automatic test_register_index();
		int i;
		wait_idle();
		for (i = SPARE_INDEX_FIRST; i <= SPARE_INDEX_LAST; i++)
			cfg_write(CFG_IDX_W'(i), '0);
		cfg_we <= 1'b0;
		send_group(uniform_group(16'hFFFE, 4'd8, 1'b1));
		send_group(uniform_group(16'hFFFF, 4'd8, 1'b1));
	endtask

	task automatic test_random_traffic();
		trig_cfg_t c;
		int        p;
		int        n;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			c = '0;
			case (p)
				0: ;
				1: c.rise_mask = '1;
				2: c.fall_mask = '1;
				3: begin
					c.level_mask = '1;
					c.level_value = '1;
				end
				default: c = make_trigger();
			endcase
			wait_idle();
			program_trigger(c);
			src_gaps = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
			sink_stalls = (p != RANDOM_PHASES - 1) && (p % 3 != 1);
			for (n = 0; n < PHASE_GROUPS; n++)
				send_group(make_group());
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		trigger_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				trigger_bus.ready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 8);
				trigger_bus.ready <= 1'b0;
			end else begin
				trigger_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		trig_result_t want;
		if (trigger_bus.valid === 1'b1 && trigger_bus.ready === 1'b1) begin
			if (expected_triggers.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected trigger beat at cycle %0d: offset %0d found %0b",
						cycle_count, trigger_bus.hit_offset, trigger_bus.found);
			end else begin
				want = expected_triggers.pop_front();
				if (trigger_bus.hit_offset !== want.offset ||
					trigger_bus.found !== want.found) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"trigger mismatch at cycle %0d: ",
							"expected offset %0d found %0b, got offset %0d found %0b"},
							cycle_count, want.offset, want.found,
							trigger_bus.hit_offset, trigger_bus.found);
				end
				if (want.found)
					triggers_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("trigger_sample_locator_core_test failed");
			$finish;
		end
	end

	initial begin
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= '0;
		cfg_wdata               <= '0;
		samples_bus.valid       <= 1'b0;
		samples_bus.sample_0    <= '0;
		samples_bus.sample_1    <= '0;
		samples_bus.sample_2    <= '0;
		samples_bus.sample_3    <= '0;
		samples_bus.sample_4    <= '0;
		samples_bus.sample_5    <= '0;
		samples_bus.sample_6    <= '0;
		samples_bus.sample_7    <= '0;
		samples_bus.valid_count <= '0;
		samples_bus.armed       <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_level_trigger();
		test_edge_trigger();
		test_register_index();
		test_random_traffic();
		wait_idle();
		$display("sent %0d sample groups under %0d trigger settings, %0d triggers located",
			groups_sent, settings_used, triggers_seen);
		$display("%0d mismatches over %0d cycles", mismatches, cycle_count);
		if (mismatches == 0)
			$display("trigger_sample_locator_core_test passed");
		else
			$display("trigger_sample_locator_core_test failed");
		$finish;
	end

endmodule

@@ files.f @@
src/tsl_pkg.sv
src/tsl_group_if.sv
src/tsl_result_if.sv
src/tsl_lane.sv
src/tsl_merge.sv
src/trigger_sample_locator_core.sv
tb/sv/trigger_sample_locator_core_test.sv
